@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the vector clock engine
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/vce_pkg.sv @@
// ----------------------------------------------------------------------------
// vce_pkg
// types, codes and widths shared by the vector clock engine modules
// ----------------------------------------------------------------------------
package vce_pkg;

    // field widths
    localparam int OP_W        = 3;
    localparam int INDEX_W     = 4;
    localparam int VALUE_W     = 32;
    localparam int TDATA_W     = 40;
    localparam int PAD_W       = TDATA_W - INDEX_W - VALUE_W;

    // defaults and sizes
    localparam int PROCESSES_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [VALUE_W-1:0] CLOCK_MAX  = '1;
    localparam logic [VALUE_W-1:0] CLOCK_ZERO = '0;

    // operation codes on the input channel
    localparam logic [OP_W-1:0] OP_INTERNAL   = 3'd0;
    localparam logic [OP_W-1:0] OP_SEND       = 3'd1;
    localparam logic [OP_W-1:0] OP_RECV_START = 3'd2;
    localparam logic [OP_W-1:0] OP_RECV_TUPLE = 3'd3;
    localparam logic [OP_W-1:0] OP_SEND_ABORT = 3'd4;

    // classified work for the back end
    typedef enum logic [1:0] {
        KIND_BUMP,
        KIND_SEND,
        KIND_MERGE,
        KIND_ABORT
    } vce_kind_t;

    typedef struct packed {
        vce_kind_t            kind;
        logic [INDEX_W-1:0]   index;
        logic [VALUE_W-1:0]   value;
    } vce_req_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEND
    } vce_state_t;

    typedef struct packed {
        logic busy;
        logic sending;
    } vce_status_t;

endpackage

@@ hw/rtl/vce_ram.sv @@
// ----------------------------------------------------------------------------
// vce_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module vce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/vce_front.sv @@
// ----------------------------------------------------------------------------
// vce_front
// accepts input requests, classifies them and queues work for the back end
// ----------------------------------------------------------------------------
module vce_front
    import vce_pkg::*;
#(
    parameter int PROCESSES = PROCESSES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]    s_tuser,
    output vce_req_t           req,
    output logic               req_valid,
    input  logic               req_ready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    vce_req_t           q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic [INDEX_W-1:0] in_index;
    logic [VALUE_W-1:0] in_value;
    vce_req_t           in_req;
    logic               in_keep;
    logic               push;
    logic               pop;

    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_value = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];

    // classify; unknown codes and out-of-range tuples are dropped here
    always_comb begin
        in_req.index = in_index;
        in_req.value = in_value;
        in_req.kind  = KIND_BUMP;
        in_keep      = 1'b0;
        unique case (s_tuser)
            OP_INTERNAL, OP_RECV_START: begin
                in_req.kind = KIND_BUMP;
                in_keep     = 1'b1;
            end
            OP_SEND: begin
                in_req.kind = KIND_SEND;
                in_keep     = 1'b1;
            end
            OP_RECV_TUPLE: begin
                in_req.kind = KIND_MERGE;
                in_keep     = (32'(in_index) < 32'(PROCESSES));
            end
            OP_SEND_ABORT: begin
                in_req.kind = KIND_ABORT;
                in_keep     = 1'b1;
            end
            default: begin
                in_keep = 1'b0;
            end
        endcase
    end

    assign s_tready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign req_valid = (count_reg != '0);
    assign req       = q_reg[rd_ptr_reg];

    assign push = s_tvalid && s_tready && in_keep;
    assign pop  = req_valid && req_ready;

    // queue pointer bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

@@ hw/rtl/vce_back.sv @@
// ----------------------------------------------------------------------------
// vce_back
// executes queued work against the clock ram and streams send tuples
// ----------------------------------------------------------------------------
module vce_back
    import vce_pkg::*;
#(
    parameter int PROCESSES = PROCESSES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [INDEX_W-1:0] own_id,
    input  vce_req_t           req,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,
    output vce_status_t        status
);

    localparam int IDX_W = $clog2(PROCESSES);

    vce_state_t         state_reg, state_next;
    vce_kind_t          kind_reg, kind_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] own_val_reg, own_val_next;

    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;

    logic [PROCESSES-1:0] valid_reg;
    logic                 rd_valid_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic               own_ok;
    logic [IDX_W-1:0]   own_addr;
    logic [VALUE_W-1:0] cur_val;
    logic [VALUE_W-1:0] own_val_cur;
    logic               out_free;
    logic               walk_last;

    vce_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (PROCESSES)
    ) u_clock_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entries never written read as zero
    assign cur_val     = rd_valid_reg ? ram_rdata : CLOCK_ZERO;
    assign own_ok      = (32'(own_id) < 32'(PROCESSES));
    assign own_addr    = IDX_W'(own_id);
    assign out_free    = !out_valid_reg || m_tready;
    assign walk_last   = (cnt_reg == IDX_W'(PROCESSES - 1));
    assign own_val_cur = (cnt_reg == own_addr) ? cur_val : own_val_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        own_val_next   = own_val_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = val_reg;
        ram_re         = 1'b0;
        ram_raddr      = own_addr;
        req_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    kind_next = req.kind;
                    val_next  = req.value;
                    ram_re    = 1'b1;
                    if (req.kind == KIND_SEND) begin
                        ram_raddr  = '0;
                        cnt_next   = '0;
                        state_next = ST_SEND;
                    end else begin
                        ram_raddr  = (req.kind == KIND_MERGE) ? IDX_W'(req.index) : own_addr;
                        addr_next  = ram_raddr;
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                // read-modify-write of one entry
                unique case (kind_reg)
                    KIND_MERGE: begin
                        ram_we    = (val_reg > cur_val);
                        ram_wdata = val_reg;
                    end
                    KIND_ABORT: begin
                        ram_we    = own_ok && (cur_val != CLOCK_ZERO);
                        ram_wdata = cur_val - VALUE_W'(1);
                    end
                    default: begin
                        ram_we    = own_ok && (cur_val != CLOCK_MAX);
                        ram_wdata = cur_val + VALUE_W'(1);
                    end
                endcase
                state_next = ST_IDLE;
            end
            ST_SEND: begin
                // one entry per cycle while the output slot frees up
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_index_next = INDEX_W'(cnt_reg);
                    out_value_next = cur_val;
                    out_last_next  = walk_last;
                    own_val_next   = own_val_cur;
                    if (walk_last) begin
                        ram_we     = own_ok && (own_val_cur != CLOCK_MAX);
                        ram_waddr  = own_addr;
                        ram_wdata  = own_val_cur + VALUE_W'(1);
                        state_next = ST_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = cnt_reg + IDX_W'(1);
                        cnt_next  = cnt_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (ram_re) begin
                rd_valid_reg <= valid_reg[ram_raddr];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        addr_reg      <= addr_next;
        val_reg       <= val_next;
        cnt_reg       <= cnt_next;
        own_val_reg   <= own_val_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = {{PAD_W{1'b0}}, out_value_reg, out_index_reg};
    assign m_tlast        = out_last_reg;
    assign status.busy    = (state_reg != ST_IDLE);
    assign status.sending = (state_reg == ST_SEND);

endmodule

@@ hw/rtl/vector_clock_engine_unit.sv @@
// ----------------------------------------------------------------------------
// vector_clock_engine_unit
// vector clock keeper: local, send, receive and abort events, send tuples out
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | notes
//  s_       | in  | tuser: operation; tdata: index, value     | one event per request
//  m_       | out | tdata: out_index, out_value; tlast: last  | PROCESSES per send
//  cfg_     | in  | cfg_data: own_id                          | always ready
//
//  internal, receive start, receive tuple, abort: the back end reads the clock
//  ram entry in ST_IDLE, then writes it back in ST_EXEC through the write port
//  send: one entry read per cycle while m_tready is high
//  reset clears per-entry valid bits at once; no clearing pass is needed
//  a 2-deep request queue holds two requests while a send waits on m_tready
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vector_clock_engine_unit
    import vce_pkg::*;
#(
    parameter int PROCESSES = PROCESSES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // tdata: entry_index [3:0], entry_value [35:4], zero pad [39:36]
    input  logic [TDATA_W-1:0] s_tdata,
    // tuser: operation [2:0]
    input  logic [OP_W-1:0]    s_tuser,
    input  logic               s_tvalid,
    output logic               s_tready,
    // tdata: out_index [3:0], out_value [35:4], zero pad [39:36]
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_data
);

    logic [INDEX_W-1:0] own_id_reg;
    vce_req_t           req;
    logic               req_valid;
    logic               req_ready;
    logic               req_pop;
    vce_status_t        status;

    // own index register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            own_id_reg <= cfg_data;
        end
    end

    vce_front #(
        .PROCESSES (PROCESSES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .req       (req),
        .req_valid (req_valid),
        .req_ready (req_ready)
    );

    vce_back #(
        .PROCESSES (PROCESSES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .own_id    (own_id_reg),
        .req       (req),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .status    (status)
    );

    // request handed from the queue to the back end
    assign req_pop = req_valid && req_ready;

    // checks
    `ASSERT_AT(a_out_from_send, aclk, aresetn, $rose(m_tvalid) |-> $past(status.sending), "stray tuple")
    `ASSERT_AT(a_pop_starts_work, aclk, aresetn, req_pop |=> status.busy, "idle after pop")
    `ASSERT_NEVER(a_pop_while_busy, aclk, aresetn, req_ready && status.busy, "ready while busy")

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks vector_clock_engine_unit against a cycle-free model of the vector
// clock: every accepted event updates the model, every send queues the
// tuples it must emit, and each tuple on m_ is matched in order
// ----------------------------------------------------------------------------
module tb_top;
    import vce_pkg::*;

    localparam int NPROC        = PROCESSES_DEF;
    localparam int STALL_MAX    = 10;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_OFF_LEN = 150;
    localparam int PHASE_ITEMS  = 55;

    // operation codes with no meaning for the block
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               last;
    } clock_tuple_t;

    logic               aclk;
    logic               aresetn;
    logic [TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]    s_tuser;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [INDEX_W-1:0] cfg_data;

    // model of the vector clock and the tuples still owed by the block
    logic [VALUE_W-1:0] clock_model [NPROC];
    logic [INDEX_W-1:0] own_model;
    clock_tuple_t       tuples_due [$];

    int error_count  = 0;
    int events_sent  = 0;
    int idle_cycles  = 0;
    int hold_off_req = 0;
    bit src_burst    = 1'b0;
    bit sink_burst   = 1'b0;

    vector_clock_engine_unit #(
        .PROCESSES (NPROC)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // own entry increment, saturating
    task automatic bump_own();
        if (int'(own_model) < NPROC && clock_model[own_model] != CLOCK_MAX) begin
            clock_model[own_model] = clock_model[own_model] + 1'b1;
        end
    endtask

    // update the clock model for one event, queue the tuples of a send
    task automatic step_vector_clock(input logic [OP_W-1:0] op,
                                     input logic [INDEX_W-1:0] idx,
                                     input logic [VALUE_W-1:0] val);
        clock_tuple_t t;
        case (op)
            OP_INTERNAL, OP_RECV_START: begin
                bump_own();
            end
            OP_SEND: begin
                for (int i = 0; i < NPROC; i++) begin
                    t.index = INDEX_W'(i);
                    t.value = clock_model[i];
                    t.last  = (i == NPROC - 1);
                    tuples_due = {tuples_due, t};
                end
                bump_own();
            end
            OP_RECV_TUPLE: begin
                if (int'(idx) < NPROC && val > clock_model[idx]) begin
                    clock_model[idx] = val;
                end
            end
            OP_SEND_ABORT: begin
                if (int'(own_model) < NPROC && clock_model[own_model] != CLOCK_ZERO) begin
                    clock_model[own_model] = clock_model[own_model] - 1'b1;
                end
            end
            default: begin
            end
        endcase
    endtask

    // offer one event on s_ and wait for the request to be taken
    task automatic offer_event(input logic [OP_W-1:0] op,
                               input logic [INDEX_W-1:0] idx,
                               input logic [VALUE_W-1:0] val);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, STALL_MAX);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {{PAD_W{1'b0}}, val, idx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        step_vector_clock(op, idx, val);
        if (op <= OP_SEND_ABORT) begin
            events_sent++;
        end
    endtask

    // lower s_tvalid, wait for all owed tuples and let the back end settle
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tuples_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // own_id write, only with the block idle
    task automatic write_own_id(input logic [INDEX_W-1:0] id);
        wait_drained();
        @(negedge aclk);
        cfg_data  <= id;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        own_model = id;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // tuple value: often close to the stored entry, else random or near an extreme
    function automatic logic [VALUE_W-1:0] pick_value(input logic [INDEX_W-1:0] idx);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: pick_value = clock_model[idx] + VALUE_W'($urandom_range(0, 4)) - 2;
            4, 5, 6:    pick_value = $urandom;
            7:          pick_value = CLOCK_MAX;
            8:          pick_value = CLOCK_MAX - VALUE_W'($urandom_range(0, 3));
            default:    pick_value = VALUE_W'($urandom_range(0, 3));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------

    // send straight after reset, then again after its own increment
    task automatic test_send_after_reset();
        offer_event(OP_SEND, '0, '0);
        offer_event(OP_SEND, '0, '0);
    endtask

    // local events, abort at zero, unknown operations
    task automatic test_local_events();
        write_own_id(4'd7);
        offer_event(OP_SEND_ABORT, '0, '0);
        offer_event(OP_INTERNAL, '0, '0);
        offer_event(OP_RECV_START, '0, '0);
        offer_event(OP_SEND_ABORT, '0, '0);
        offer_event(OP_SEND_ABORT, '0, '0);
        offer_event(OP_SEND_ABORT, '0, '0);
        offer_event(OP_RSVD_5, 4'hf, CLOCK_MAX);
        offer_event(OP_RSVD_6, 4'h0, CLOCK_ZERO);
        offer_event(OP_RSVD_7, 4'ha, 32'h5555_aaaa);
        offer_event(OP_SEND, '0, '0);
    endtask

    // merges: raise, smaller value kept out, index extremes
    task automatic test_merge();
        offer_event(OP_RECV_TUPLE, 4'h0, CLOCK_MAX);
        offer_event(OP_RECV_TUPLE, 4'h0, 32'd5);
        offer_event(OP_RECV_TUPLE, 4'hf, 32'ha5a5_a5a5);
        offer_event(OP_RECV_TUPLE, 4'hf, 32'h5a5a_5a5a);
        offer_event(OP_RECV_TUPLE, 4'h9, CLOCK_ZERO);
        offer_event(OP_SEND, '0, '0);
    endtask

    // own entry at its maximum: increments hold, abort steps down
    task automatic test_saturation();
        write_own_id(4'd15);
        offer_event(OP_RECV_TUPLE, 4'hf, CLOCK_MAX);
        offer_event(OP_INTERNAL, '0, '0);
        offer_event(OP_RECV_START, '0, '0);
        offer_event(OP_SEND, '0, '0);
        offer_event(OP_SEND_ABORT, '0, '0);
        offer_event(OP_SEND, '0, '0);
    endtask

    // ------------------------------------------------------------------------
    // random tests
    // ------------------------------------------------------------------------

    // mostly whole messages and sends, some noise, under one own_id
    task automatic test_random_phase(input logic [INDEX_W-1:0] id, input bit sb,
                                     input bit kb);
        int goal;
        int r;
        int n;
        logic [INDEX_W-1:0] idx;
        write_own_id(id);
        src_burst  = sb;
        sink_burst = kb;
        goal = events_sent + PHASE_ITEMS;
        while (events_sent < goal) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                // received message: start, then a run of tuples
                offer_event(OP_RECV_START, INDEX_W'($urandom), $urandom);
                n = ($urandom_range(0, 3) == 0) ? NPROC : $urandom_range(1, 5);
                for (int k = 0; k < n; k++) begin
                    idx = (n == NPROC) ? INDEX_W'(k) : INDEX_W'($urandom_range(0, NPROC - 1));
                    offer_event(OP_RECV_TUPLE, idx, pick_value(idx));
                end
            end else if (r < 55) begin
                offer_event(OP_SEND, INDEX_W'($urandom), $urandom);
                if ($urandom_range(0, 1) == 1) begin
                    offer_event(OP_SEND_ABORT, INDEX_W'($urandom), $urandom);
                end
            end else if (r < 70) begin
                offer_event(OP_INTERNAL, INDEX_W'($urandom), $urandom);
            end else if (r < 80) begin
                offer_event(OP_SEND_ABORT, INDEX_W'($urandom), $urandom);
            end else if (r < 85) begin
                case ($urandom_range(0, 2))
                    0:       offer_event(OP_RSVD_5, INDEX_W'($urandom), $urandom);
                    1:       offer_event(OP_RSVD_6, INDEX_W'($urandom), $urandom);
                    default: offer_event(OP_RSVD_7, INDEX_W'($urandom), $urandom);
                endcase
            end else begin
                idx = INDEX_W'($urandom_range(0, NPROC - 1));
                offer_event(OP_RECV_TUPLE, idx, pick_value(idx));
            end
        end
    endtask

    // receiver holds off while sends keep coming, so s_ must stall
    task automatic test_output_backpressure();
        write_own_id(INDEX_W'($urandom_range(0, NPROC - 1)));
        src_burst    = 1'b1;
        sink_burst   = 1'b1;
        hold_off_req = HOLD_OFF_LEN;
        repeat (6) begin
            offer_event(OP_SEND, '0, '0);
            offer_event(OP_INTERNAL, '0, '0);
            offer_event(OP_RECV_TUPLE, INDEX_W'($urandom), $urandom);
        end
        sink_burst = 1'b0;
        src_burst  = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_INTERNAL;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        for (int i = 0; i < NPROC; i++) begin
            clock_model[i] = CLOCK_ZERO;
        end
        own_model = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_send_after_reset();
        test_local_events();
        test_merge();
        test_saturation();
        test_random_phase(4'd0, 1'b1, 1'b1);
        test_random_phase(4'd15, 1'b0, 1'b0);
        test_random_phase(INDEX_W'($urandom_range(1, 14)), 1'b1, 1'b0);
        test_random_phase(INDEX_W'($urandom_range(0, 15)), 1'b0, 1'b1);
        test_output_backpressure();

        wait_drained();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // m_tready: random stall per tuple, long hold-off on request
    initial begin : sink_drive
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_req > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_req) @(negedge aclk);
                hold_off_req = 0;
            end
            gap = sink_burst ? 0 : $urandom_range(0, STALL_MAX);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && hold_off_req == 0);
        end
    end

    // match each emitted tuple against the oldest one owed
    always @(posedge aclk) begin : tuple_check
        clock_tuple_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tuples_due.size() == 0) begin
                $error("unexpected tuple: index %0d value %h last %b",
                       m_tdata[INDEX_W-1:0], m_tdata[INDEX_W+VALUE_W-1:INDEX_W], m_tlast);
                error_count++;
            end else begin
                want = tuples_due.pop_front();
                if (m_tdata[INDEX_W-1:0] !== want.index) begin
                    $error("out_index: expected %0d, got %0d", want.index,
                           m_tdata[INDEX_W-1:0]);
                    error_count++;
                end
                if (m_tdata[INDEX_W+VALUE_W-1:INDEX_W] !== want.value) begin
                    $error("out_value: expected %h, got %h", want.value,
                           m_tdata[INDEX_W+VALUE_W-1:INDEX_W]);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_entry: expected %b, got %b", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted request
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

@@ vector_clock_engine_unit.f @@
+incdir+hw/rtl
hw/rtl/vce_pkg.sv
hw/rtl/vce_ram.sv
hw/rtl/vce_front.sv
hw/rtl/vce_back.sv
hw/rtl/vector_clock_engine_unit.sv
verif/tb_top.sv
